### rtl/cpsm_pkg.sv
`default_nettype none
package cpsm_pkg;

  // defaults of the top level parameters
  localparam int DEF_CHANNELS   = 2;
  localparam int DEF_TIMER_BITS = 16;

  // field widths
  localparam int OP_W       = 2;
  localparam int CAP_W      = 16;
  localparam int CLK_RATE_W = 24;
  localparam int MPH_W      = 16;
  localparam int VEL_W      = 16;
  localparam int STALE_W    = 8;
  localparam int OVF_W      = 8;
  localparam int FREQ_W     = 24;
  localparam int PROD_W     = FREQ_W + MPH_W;

  // stream packing
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 40;
  localparam int M_TUSER_W = 1;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_RATE      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_METRES_PER_HOLE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STALE_OVERFLOWS = 8'd3;

  localparam logic [CLK_RATE_W-1:0] RST_CLOCK_RATE      = 24'd1000000;
  localparam logic [MPH_W-1:0]      RST_METRES_PER_HOLE = 16'd669;
  localparam logic [VEL_W-1:0]      RST_VELOCITY_LIMIT  = 16'd52429;
  localparam logic [STALE_W-1:0]    RST_STALE_OVERFLOWS = 8'd3;

  // operation codes
  localparam logic [OP_W-1:0] OP_CAPTURE  = 2'd0;
  localparam logic [OP_W-1:0] OP_OVERFLOW = 2'd1;
  localparam logic [OP_W-1:0] OP_READ     = 2'd2;

  localparam logic [OVF_W-1:0] OVF_MAX = 8'hFF;

endpackage
`default_nettype wire

### rtl/capture_period_speed_meter.sv
// steps: overflow, read and start-edge items pass S_EXEC and then S_OUT; an edge
// that closes a positive period passes S_EXEC, S_DIV (serial divider), S_MUL, S_CHECK
// and S_OUT, the divider setting the rate; a zero or negative period skips S_DIV
// throughput: one item at a time, input ready again right after its result is loaded
// into the output register; a stalled result holds the block
// reset: rst is synchronous, clears all channel state, loads register defaults
`default_nettype none
module capture_period_speed_meter #(
  parameter int CHANNELS   = cpsm_pkg::DEF_CHANNELS,
  parameter int TIMER_BITS = cpsm_pkg::DEF_TIMER_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // capture_value [15:0], motor_running [16], zero fill [23:17]
  input  wire logic [cpsm_pkg::S_TDATA_W-1:0] s_tdata,
  // operation [1:0], channel [2]
  input  wire logic [cpsm_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // velocity [15:0], frequency_hz [39:16]
  output logic [cpsm_pkg::M_TDATA_W-1:0]      m_tdata,
  // measurement_done [0]
  output logic [cpsm_pkg::M_TUSER_W-1:0]      m_tuser,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cpsm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cpsm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SPAN_W = TIMER_BITS + cpsm_pkg::OVF_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_DIV   = 6'b000100,
    S_MUL   = 6'b001000,
    S_CHECK = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [cpsm_pkg::CLK_RATE_W-1:0] clock_rate;
  logic [cpsm_pkg::MPH_W-1:0]      metres_per_hole;
  logic [cpsm_pkg::VEL_W-1:0]      velocity_limit;
  logic [cpsm_pkg::STALE_W-1:0]    stale_overflows;

  // per channel state
  logic                          waiting_for_end [CHANNELS];
  logic [TIMER_BITS-1:0]         start_time      [CHANNELS];
  logic [cpsm_pkg::OVF_W-1:0]    overflow_count  [CHANNELS];
  logic [cpsm_pkg::VEL_W-1:0]    stored_velocity [CHANNELS];
  logic [cpsm_pkg::FREQ_W-1:0]   last_frequency  [CHANNELS];

  // item being worked on
  logic [cpsm_pkg::OP_W-1:0]   op_r;
  logic [CH_W-1:0]             ch_r;
  logic                        ch_ok;
  logic [TIMER_BITS-1:0]       cap_r;
  logic                        running;
  logic                        done_r;
  logic [cpsm_pkg::FREQ_W-1:0] freq_r;
  logic [cpsm_pkg::PROD_W-1:0] prod;

  logic [SPAN_W-1:0]           span;
  logic [SPAN_W:0]             diff;
  logic                        ticks_pos;
  logic                        div_start;
  logic                        div_done;
  logic [cpsm_pkg::FREQ_W-1:0] div_quo;
  logic                        s_accept;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign s_accept  = s_tvalid && s_tready;

  // period in ticks, overflows stacked above the captured count
  assign span      = {overflow_count[ch_r], cap_r};
  assign diff      = {1'b0, span} - (SPAN_W + 1)'(start_time[ch_r]);
  assign ticks_pos = !diff[SPAN_W] && (diff[SPAN_W-1:0] != '0);
  assign div_start = (state == S_EXEC) && ch_ok && (op_r == cpsm_pkg::OP_CAPTURE) &&
                     waiting_for_end[ch_r] && ticks_pos;

  cpsm_divider #(
    .DIVISOR_W(SPAN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (clock_rate),
    .divisor  (diff[SPAN_W-1:0]),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_rate      <= cpsm_pkg::RST_CLOCK_RATE;
      metres_per_hole <= cpsm_pkg::RST_METRES_PER_HOLE;
      velocity_limit  <= cpsm_pkg::RST_VELOCITY_LIMIT;
      stale_overflows <= cpsm_pkg::RST_STALE_OVERFLOWS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cpsm_pkg::REG_CLOCK_RATE:      clock_rate      <= cfg_data;
        cpsm_pkg::REG_METRES_PER_HOLE: metres_per_hole <= cfg_data[cpsm_pkg::MPH_W-1:0];
        cpsm_pkg::REG_VELOCITY_LIMIT:  velocity_limit  <= cfg_data[cpsm_pkg::VEL_W-1:0];
        cpsm_pkg::REG_STALE_OVERFLOWS: stale_overflows <= cfg_data[cpsm_pkg::STALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      done_r   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        waiting_for_end[i] <= 1'b0;
        start_time[i]      <= '0;
        overflow_count[i]  <= '0;
        stored_velocity[i] <= '0;
        last_frequency[i]  <= '0;
      end
    end else begin
      // in S_OUT the output register is refilled instead
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_accept) begin
            done_r <= 1'b0;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_OUT;
          if (ch_ok) begin
            case (op_r)
              cpsm_pkg::OP_CAPTURE: begin
                if (!waiting_for_end[ch_r]) begin
                  start_time[ch_r]      <= cap_r;
                  overflow_count[ch_r]  <= '0;
                  waiting_for_end[ch_r] <= 1'b1;
                end else begin
                  waiting_for_end[ch_r] <= 1'b0;
                  done_r                <= 1'b1;
                  // a non-positive period gives zero frequency
                  if (ticks_pos) begin
                    state <= S_DIV;
                  end else begin
                    freq_r <= '0;
                    state  <= S_MUL;
                  end
                end
              end
              cpsm_pkg::OP_OVERFLOW: begin
                if (overflow_count[ch_r] != cpsm_pkg::OVF_MAX) begin
                  overflow_count[ch_r] <= overflow_count[ch_r] + 1'b1;
                end
              end
              cpsm_pkg::OP_READ: begin
                if (!running || (overflow_count[ch_r] > stale_overflows)) begin
                  stored_velocity[ch_r] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            freq_r <= div_quo;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          prod                 <= freq_r * metres_per_hole;
          last_frequency[ch_r] <= freq_r;
          state                <= S_CHECK;
        end
        S_CHECK: begin
          if (prod < cpsm_pkg::PROD_W'(velocity_limit)) begin
            stored_velocity[ch_r] <= prod[cpsm_pkg::VEL_W-1:0];
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // wait for the output register to be free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (s_accept) begin
      op_r    <= s_tuser[cpsm_pkg::OP_W-1:0];
      ch_r    <= CH_W'(s_tuser[cpsm_pkg::OP_W]);
      ch_ok   <= 32'(s_tuser[cpsm_pkg::OP_W]) < CHANNELS;
      cap_r   <= TIMER_BITS'(s_tdata[cpsm_pkg::CAP_W-1:0]);
      running <= s_tdata[cpsm_pkg::CAP_W];
    end
    if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
      if (ch_ok) begin
        m_tdata <= {last_frequency[ch_r], stored_velocity[ch_r]};
      end else begin
        m_tdata <= '0;
      end
      m_tuser <= done_r;
    end
  end

endmodule
`default_nettype wire

### rtl/cpsm_divider.sv
`default_nettype none
module cpsm_divider #(
  parameter int DIVISOR_W = cpsm_pkg::DEF_TIMER_BITS + cpsm_pkg::OVF_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [cpsm_pkg::FREQ_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]        divisor,
  output logic                             done,
  output logic [cpsm_pkg::FREQ_W-1:0]      quotient
);

  localparam int QW    = cpsm_pkg::FREQ_W;
  localparam int CMP_W = (DIVISOR_W > QW + 1) ? DIVISOR_W : QW + 1;
  localparam int CNT_W = $clog2(QW);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [QW-1:0]    rem;
  logic [QW-1:0]    quo;
  logic [DIVISOR_W-1:0] dvsr;

  logic [CMP_W-1:0] trial;
  logic [CMP_W-1:0] dvsr_ext;
  logic [CMP_W-1:0] diff;
  logic             ge;

  // restoring division, one quotient bit per cycle
  assign trial    = CMP_W'({rem, quo[QW-1]});
  assign dvsr_ext = CMP_W'(dvsr);
  assign ge       = trial >= dvsr_ext;
  assign diff     = trial - dvsr_ext;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= ge ? QW'(diff) : QW'(trial);
      quo <= {quo[QW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### rtl/cpsm_checker.sv
`default_nettype none
module cpsm_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [cpsm_pkg::M_TDATA_W-1:0]  m_tdata,
  input wire logic [cpsm_pkg::M_TUSER_W-1:0]  m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accepted item");

  // a new result appears only as the block finishes an item
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready && !$past(s_tready))
    else $error("result without an item in flight");

endmodule

bind capture_period_speed_meter cpsm_checker u_cpsm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
